FILE: sv/assert_macros.svh
// assertion helper macros for the duplicate filter checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tdwf_pkg.sv
//------------------------------------------------------------------------------
// tdwf_pkg
// shared types and constants for the tag duplicate window filter
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdwf_pkg;
	localparam int TableDepthDef = 256;
	localparam int KeyBytesDef   = 32;
	localparam int KeyWords      = 4;
	localparam int InBytes       = 32;
	localparam logic [15:0] HitsMax = 16'hffff;

	localparam logic [1:0] REQ_TAG   = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [0:0] CFG_FILTER_ON = 1'b0;
	localparam logic [0:0] CFG_WINDOW    = 1'b1;

	// entry metadata as stored in the meta memory
	typedef struct packed {
		logic [5:0]  len;
		logic [15:0] hits;
		logic [15:0] remaining;
	} meta_t;

	// mask of the valid bytes of 64-bit key word w for a key of len bytes
	function automatic logic [63:0] word_mask(input logic [5:0] len, input int w);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (int'(len) > w * 8 + b) begin
				m[b*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction
endpackage

FILE: sv/tdwf_store.sv
//------------------------------------------------------------------------------
// tdwf_store
// entry memories: key words and metadata, registered synchronous read
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdwf_store #(
	parameter int TABLE_DEPTH = 256,
	parameter int KW          = 4,
	parameter int AW          = 8
) (
	input  logic                   clk,
	input  logic [AW-1:0]          rd_addr,
	output logic [KW*64-1:0]       rd_key,
	output tdwf_pkg::meta_t        rd_meta,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  logic [KW*64-1:0]       wr_key,
	input  tdwf_pkg::meta_t        wr_meta
);
	import tdwf_pkg::*;

	logic [KW*64-1:0] key_mem [TABLE_DEPTH];
	meta_t            meta_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]  <= wr_key;
			meta_mem[wr_addr] <= wr_meta;
		end
		rd_key  <= key_mem[rd_addr];
		rd_meta <= meta_mem[rd_addr];
	end
endmodule

FILE: sv/tdwf_ctrl.sv
//------------------------------------------------------------------------------
// tdwf_ctrl
// sequencer walking the ring for lookup, append and aging compaction
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdwf_ctrl #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_BYTES   = 32,
	parameter int AW          = 8,
	parameter int CW          = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             req_type,
	input  logic [5:0]             key_len,
	input  logic [255:0]           key_in,
	input  logic                   filter_on,
	input  logic [15:0]            window_ticks,
	output logic [AW-1:0]          rd_addr,
	input  logic [255:0]           rd_key,
	input  tdwf_pkg::meta_t        rd_meta,
	output logic                   wr_en,
	output logic [AW-1:0]          wr_addr,
	output logic [255:0]           wr_key,
	output tdwf_pkg::meta_t        wr_meta,
	output logic                   done,
	output logic                   pass_tag,
	output logic [15:0]            seen_count,
	output logic                   evicted,
	output logic [8:0]             expired_count,
	output logic [8:0]             occupancy
);
	import tdwf_pkg::*;

	localparam int LenCap = (KEY_BYTES < InBytes) ? KEY_BYTES : InBytes;
	localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_AGE  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t        state_q;
	logic          tick_q;
	logic [5:0]    len_q;
	logic [255:0]  key_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] kept_q;
	logic [CW-1:0] held_q;
	logic [AW-1:0] oldest_q;
	logic          hit_q;
	logic [15:0]   seen_q;
	logic          evict_q;
	logic [CW-1:0] exp_q;
	logic          pass_q;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] pos);
		logic [CW:0] s;
		s = {1'b0, {(CW-AW){1'b0}}, base} + {1'b0, pos};
		if (s >= {1'b0, Depth}) begin
			s = s - {1'b0, Depth};
		end
		return s[AW-1:0];
	endfunction

	logic [5:0]   cap_len;
	logic [255:0] masked_key;
	always_comb begin
		cap_len = (int'(key_len) > LenCap) ? 6'(LenCap) : key_len;
		for (int w = 0; w < KeyWords; w++) begin
			masked_key[w*64 +: 64] = key_in[w*64 +: 64] & word_mask(cap_len, w);
		end
	end

	logic match;
	assign match = (rd_meta.len == len_q) && (rd_key == key_q);

	assign busy = (state_q != ST_IDLE);
	assign rd_addr = slot(oldest_q, idx_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot(oldest_q, kept_q);
		wr_key  = rd_key;
		wr_meta = rd_meta;
		if (state_q == ST_CMP && match) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr;
			wr_meta.hits = (rd_meta.hits == HitsMax) ? HitsMax : rd_meta.hits + 16'd1;
		end else if (state_q == ST_AGE && rd_meta.remaining > 16'd1) begin
			wr_en = 1'b1;
			wr_meta.remaining = rd_meta.remaining - 16'd1;
		end else if (state_q == ST_DONE && !tick_q && !hit_q && pass_q && filter_on) begin
			// append at the tail (after any eviction)
			wr_en   = 1'b1;
			wr_addr = slot(oldest_q, held_q);
			wr_key  = key_q;
			wr_meta.len = len_q;
			wr_meta.hits = 16'd1;
			wr_meta.remaining = (window_ticks == 16'd0) ? 16'd1 : window_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			held_q   <= '0;
			oldest_q <= '0;
			done     <= 1'b0;
			idx_q    <= '0;
			kept_q   <= '0;
			tick_q   <= 1'b0;
			hit_q    <= 1'b0;
			pass_q   <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						len_q   <= cap_len;
						key_q   <= masked_key;
						idx_q   <= '0;
						kept_q  <= '0;
						hit_q   <= 1'b0;
						evict_q <= 1'b0;
						exp_q   <= '0;
						seen_q  <= '0;
						pass_q  <= 1'b0;
						tick_q  <= 1'b0;
						state_q <= ST_DONE;
						case (req_type)
							REQ_TAG: begin
								pass_q <= 1'b1;
								if (filter_on && held_q != '0) begin
									state_q <= ST_READ;
								end
							end
							REQ_TICK: begin
								tick_q <= 1'b1;
								if (filter_on && held_q != '0) begin
									state_q <= ST_READ;
								end
							end
							REQ_CLEAR: begin
								exp_q    <= held_q;
								held_q   <= '0;
								oldest_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					state_q <= tick_q ? ST_AGE : ST_CMP;
				end
				ST_CMP: begin
					if (match) begin
						hit_q   <= 1'b1;
						pass_q  <= 1'b0;
						seen_q  <= wr_meta.hits;
						state_q <= ST_DONE;
					end else if (idx_q + 1'b1 >= held_q) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_AGE: begin
					if (rd_meta.remaining > 16'd1) begin
						kept_q <= kept_q + 1'b1;
					end else begin
						exp_q <= exp_q + 1'b1;
					end
					if (idx_q + 1'b1 >= held_q) begin
						held_q  <= (rd_meta.remaining > 16'd1) ? kept_q + 1'b1 : kept_q;
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (!tick_q && !hit_q && pass_q && filter_on) begin
						seen_q <= 16'd1;
						if (held_q >= Depth) begin
							evict_q  <= 1'b1;
							oldest_q <= slot(oldest_q, CW'(1));
						end else begin
							held_q <= held_q + 1'b1;
						end
					end
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the eviction case writes to the slot about to become tail: with a full
	// ring slot(oldest, held) equals the oldest slot, which is the one dropped
	assign pass_tag      = pass_q;
	assign seen_count    = seen_q;
	assign evicted       = evict_q;
	assign expired_count = 9'(exp_q);
	assign occupancy     = 9'(held_q);
endmodule

FILE: sv/tag_duplicate_window_filter_core.sv
//------------------------------------------------------------------------------
// tag_duplicate_window_filter_core
// duplicate tag suppression table with tick-driven aging
//------------------------------------------------------------------------------
// A clear, an unused request, or any item on an empty table or with filtering
// off goes straight to the done state; otherwise a lookup or a tick walks the
// ring in arrival order one entry at a time (memory read, then compare or age
// and write back). The result strobe, done, is high for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module tag_duplicate_window_filter_core #(
	parameter int TABLE_DEPTH = tdwf_pkg::TableDepthDef,
	parameter int KEY_BYTES   = tdwf_pkg::KeyBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [5:0]  key_len,
	input  logic [63:0] key_word0,
	input  logic [63:0] key_word1,
	input  logic [63:0] key_word2,
	input  logic [63:0] key_word3,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic        pass_tag,
	output logic [15:0] seen_count,
	output logic        evicted,
	output logic [8:0]  expired_count,
	output logic [8:0]  occupancy
);
	import tdwf_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic          filter_on_q;
	logic [15:0]   window_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [255:0]  rd_key, wr_key;
	meta_t         rd_meta, wr_meta;
	logic          wr_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_on_q <= 1'b0;
			window_q    <= 16'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FILTER_ON: filter_on_q <= cfg_data[0];
				CFG_WINDOW:    window_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	tdwf_store #(.TABLE_DEPTH(TABLE_DEPTH), .KW(KeyWords), .AW(AW)) u_store (
		.clk(clk), .rd_addr(rd_addr), .rd_key(rd_key), .rd_meta(rd_meta),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key), .wr_meta(wr_meta)
	);

	tdwf_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BYTES(KEY_BYTES), .AW(AW), .CW(CW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .key_len(key_len),
		.key_in({key_word3, key_word2, key_word1, key_word0}),
		.filter_on(filter_on_q), .window_ticks(window_q),
		.rd_addr(rd_addr), .rd_key(rd_key), .rd_meta(rd_meta),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key), .wr_meta(wr_meta),
		.done(done), .pass_tag(pass_tag), .seen_count(seen_count), .evicted(evicted),
		.expired_count(expired_count), .occupancy(occupancy)
	);
endmodule

FILE: sv/tdwf_checker.sv
//------------------------------------------------------------------------------
// tdwf_checker
// port-level checks on the duplicate filter, bound to the top level
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdwf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       pass_tag,
	input logic       evicted,
	input logic [15:0] seen_count,
	input logic [8:0] occupancy
);
	`CHK_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted item not busy")
	`CHK_NEXT(a_done_single, clk, arst_n, done, !done, "done held two cycles")
	`CHK_IMPL(a_evict_pass, clk, arst_n, done && evicted, pass_tag, "eviction without pass")
	// an eviction always comes with a freshly appended entry
	`CHK_IMPL(a_evict_seen, clk, arst_n, done && evicted, seen_count == 16'd1, "eviction count not one")
	`CHK_IMPL(a_occ_range, clk, arst_n, done, occupancy <= 9'd256, "occupancy overflow")
endmodule

bind tag_duplicate_window_filter_core tdwf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.pass_tag(pass_tag), .evicted(evicted), .seen_count(seen_count),
	.occupancy(occupancy)
);

FILE: tb/tag_duplicate_window_filter_core_tb.sv
//------------------------------------------------------------------------------
// tag_duplicate_window_filter_core_tb
// Drives tag, tick, clear and unused requests into the duplicate filter core
// through directed rows and random phases at several register settings. A
// local table model predicts each result unless a directed row lists its own,
// and each done strobe is compared field by field with the oldest expectation.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tag_duplicate_window_filter_core_tb;
	import tdwf_pkg::*;

	localparam int Depth    = 256;
	localparam int LenCap   = 32;
	localparam int PoolSize = 48;
	localparam int StallMax = 20000;

	typedef struct packed {
		logic [1:0]  req;
		logic [5:0]  len;
		logic [63:0] w0;
		logic [63:0] w1;
		logic [63:0] w2;
		logic [63:0] w3;
	} tag_req_t;

	typedef struct packed {
		logic        pass;
		logic [15:0] seen;
		logic        ev;
		logic [8:0]  expc;
		logic [8:0]  occ;
	} filt_res_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_ITEM_EXP, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		tag_req_t    it;
		filt_res_t   res;
		logic [0:0]  idx;
		logic [15:0] data;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [5:0]  key_len;
	logic [63:0] key_word0, key_word1, key_word2, key_word3;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        done;
	logic        pass_tag;
	logic [15:0] seen_count;
	logic        evicted;
	logic [8:0]  expired_count;
	logic [8:0]  occupancy;

	tag_duplicate_window_filter_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .key_len(key_len),
		.key_word0(key_word0), .key_word1(key_word1),
		.key_word2(key_word2), .key_word3(key_word3),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .pass_tag(pass_tag), .seen_count(seen_count),
		.evicted(evicted), .expired_count(expired_count), .occupancy(occupancy)
	);

	// shadow of the suppression table
	logic        sh_filter_on;
	logic [15:0] sh_window;
	logic [63:0] sh_key [Depth][4];
	logic [5:0]  sh_len [Depth];
	logic [15:0] sh_hits [Depth];
	logic [15:0] sh_remain [Depth];
	logic [7:0]  sh_oldest;
	int          sh_held;

	filt_res_t   pending_results[$];
	int          error_count;
	int          stall_cycles;
	int          burst_left;

	tag_req_t    pool [PoolSize];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] key_mask(input int len, input int w);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (len > w * 8 + b) m[b*8 +: 8] = 8'hff;
		end
		return m;
	endfunction

	function automatic filt_res_t table_update(input tag_req_t it);
		filt_res_t r;
		logic [63:0] k [4];
		logic [7:0] s;
		logic [7:0] d;
		int len;
		int kept;
		bit hit;
		r = '0;
		hit = 0;
		if (it.req == REQ_TAG) begin
			if (!sh_filter_on) begin
				r.pass = 1'b1;
			end else begin
				len = (int'(it.len) > LenCap) ? LenCap : int'(it.len);
				k[0] = it.w0 & key_mask(len, 0);
				k[1] = it.w1 & key_mask(len, 1);
				k[2] = it.w2 & key_mask(len, 2);
				k[3] = it.w3 & key_mask(len, 3);
				for (int i = 0; i < sh_held && !hit; i++) begin
					s = 8'(sh_oldest + i);
					if (int'(sh_len[s]) == len && sh_key[s][0] == k[0] && sh_key[s][1] == k[1]
							&& sh_key[s][2] == k[2] && sh_key[s][3] == k[3]) begin
						if (sh_hits[s] != 16'hffff) sh_hits[s] = sh_hits[s] + 16'd1;
						r.seen = sh_hits[s];
						hit = 1;
					end
				end
				if (!hit) begin
					if (sh_held >= Depth) begin
						sh_oldest = sh_oldest + 8'd1;
						sh_held--;
						r.ev = 1'b1;
					end
					s = 8'(sh_oldest + sh_held);
					for (int w = 0; w < 4; w++) sh_key[s][w] = k[w];
					sh_len[s] = 6'(len);
					sh_hits[s] = 16'd1;
					sh_remain[s] = (sh_window == 0) ? 16'd1 : sh_window;
					sh_held++;
					r.pass = 1'b1;
					r.seen = 16'd1;
				end
			end
		end else if (it.req == REQ_TICK) begin
			if (sh_filter_on) begin
				kept = 0;
				for (int i = 0; i < sh_held; i++) begin
					s = 8'(sh_oldest + i);
					if (sh_remain[s] <= 16'd1) begin
						r.expc = r.expc + 9'd1;
					end else begin
						sh_remain[s] = sh_remain[s] - 16'd1;
						if (kept != i) begin
							d = 8'(sh_oldest + kept);
							for (int w = 0; w < 4; w++) sh_key[d][w] = sh_key[s][w];
							sh_len[d] = sh_len[s];
							sh_hits[d] = sh_hits[s];
							sh_remain[d] = sh_remain[s];
						end
						kept++;
					end
				end
				sh_held = kept;
			end
		end else if (it.req == REQ_CLEAR) begin
			r.expc = 9'(sh_held);
			sh_held = 0;
			sh_oldest = '0;
		end
		r.occ = 9'(sh_held);
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		filt_res_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = pending_results.pop_front();
				if (pass_tag !== e.pass) report("pass_tag", pass_tag, e.pass);
				if (seen_count !== e.seen) report("seen_count", seen_count, e.seen);
				if (evicted !== e.ev) report("evicted", evicted, e.ev);
				if (expired_count !== e.expc) report("expired_count", expired_count, e.expc);
				if (occupancy !== e.occ) report("occupancy", occupancy, e.occ);
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallMax) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_item(input tag_req_t it, input bit typed, input filt_res_t want);
		filt_res_t p;
		req_type = it.req;
		key_len = it.len;
		key_word0 = it.w0;
		key_word1 = it.w1;
		key_word2 = it.w2;
		key_word3 = it.w3;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		p = table_update(it);
		pending_results.push_back(typed ? want : p);
		@(negedge clk);
		start = 1'b0;
	endtask

	// sender bursts with random gaps
	task automatic sender_gap();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			repeat ($urandom_range(0, 12)) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		while (pending_results.size() != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [0:0] idx, input logic [15:0] data);
		wait_idle();
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		if (idx == CFG_FILTER_ON) sh_filter_on = data[0];
		else sh_window = data;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic tag_req_t fresh_tag();
		tag_req_t t;
		t.req = REQ_TAG;
		t.len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) :
			6'($urandom_range(0, 32));
		t.w0 = {$urandom, $urandom};
		t.w1 = {$urandom, $urandom};
		t.w2 = {$urandom, $urandom};
		t.w3 = {$urandom, $urandom};
		return t;
	endfunction

	// repeated tag from the pool, garbage above the key length
	function automatic tag_req_t pool_tag();
		tag_req_t t;
		int len;
		t = pool[$urandom_range(0, PoolSize - 1)];
		len = (int'(t.len) > LenCap) ? LenCap : int'(t.len);
		t.w0 = t.w0 ^ ({$urandom, $urandom} & ~key_mask(len, 0));
		t.w1 = t.w1 ^ ({$urandom, $urandom} & ~key_mask(len, 1));
		t.w2 = t.w2 ^ ({$urandom, $urandom} & ~key_mask(len, 2));
		t.w3 = t.w3 ^ ({$urandom, $urandom} & ~key_mask(len, 3));
		return t;
	endfunction

	task automatic random_phase(input int n, input int pct_pool, input int pct_fresh,
			input int pct_tick, input int pct_clear);
		tag_req_t t;
		int r;
		for (int i = 0; i < PoolSize; i++) pool[i] = fresh_tag();
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < pct_pool) t = pool_tag();
			else if (r < pct_pool + pct_fresh) t = fresh_tag();
			else if (r < pct_pool + pct_fresh + pct_tick) t = '{REQ_TICK, 6'($urandom),
				{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}};
			else if (r < pct_pool + pct_fresh + pct_tick + pct_clear) t = '{REQ_CLEAR,
				6'($urandom), {$urandom, $urandom}, 64'd0, 64'd0, 64'd0};
			else t = '{2'd3, 6'($urandom), {$urandom, $urandom}, 64'd0, 64'd0, 64'd0};
			send_item(t, 1'b0, '0);
			// hold off until the table has drained its queue now and then
			if ($urandom_range(0, 199) == 0) wait_idle();
			sender_gap();
		end
	endtask

	localparam logic [63:0] Ones = 64'hffff_ffff_ffff_ffff;

	row_t directed [] = '{
		'{ROW_ITEM_EXP, '{REQ_TAG, 6'd5, Ones, 0, 0, 0}, '{1, 0, 0, 0, 0}, 0, 0},
		'{ROW_ITEM_EXP, '{REQ_TICK, 6'd0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, 0, 0},
		'{ROW_ITEM_EXP, '{2'd3, 6'd63, Ones, Ones, Ones, Ones}, '{0, 0, 0, 0, 0}, 0, 0},
		'{ROW_CFG, '0, '0, CFG_WINDOW, 16'd2},
		'{ROW_CFG, '0, '0, CFG_FILTER_ON, 16'd1},
		'{ROW_ITEM_EXP, '{REQ_TAG, 6'd0, Ones, 0, 0, 0}, '{1, 1, 0, 0, 1}, 0, 0},
		'{ROW_ITEM_EXP, '{REQ_TAG, 6'd0, 0, Ones, 0, 0}, '{0, 2, 0, 0, 1}, 0, 0},
		'{ROW_ITEM_EXP, '{REQ_TAG, 6'd32, Ones, Ones, Ones, Ones}, '{1, 1, 0, 0, 2}, 0, 0},
		// length above the cap folds onto the 32-byte key
		'{ROW_ITEM_EXP, '{REQ_TAG, 6'd63, Ones, Ones, Ones, Ones}, '{0, 2, 0, 0, 2}, 0, 0},
		'{ROW_ITEM_EXP, '{REQ_TAG, 6'd8, 64'h11, 64'h5a, 0, 0}, '{1, 1, 0, 0, 3}, 0, 0},
		'{ROW_ITEM_EXP, '{REQ_TAG, 6'd8, 64'h11, Ones, 0, 0}, '{0, 2, 0, 0, 3}, 0, 0},
		'{ROW_ITEM, '{REQ_TAG, 6'd1, 64'hff00, 0, 0, 0}, '0, 0, 0},
		'{ROW_ITEM_EXP, '{2'd3, 6'd1, 0, 0, 0, 0}, '{0, 0, 0, 0, 4}, 0, 0},
		'{ROW_ITEM, '{REQ_TICK, 6'd0, 0, 0, 0, 0}, '0, 0, 0},
		'{ROW_ITEM, '{REQ_TAG, 6'd9, 64'h1234, 64'h77, 0, 0}, '0, 0, 0},
		'{ROW_ITEM, '{REQ_TICK, 6'd0, 0, 0, 0, 0}, '0, 0, 0},
		'{ROW_ITEM, '{REQ_CLEAR, 6'd0, 0, 0, 0, 0}, '0, 0, 0},
		'{ROW_ITEM, '{REQ_TAG, 6'd2, 64'habcd, 0, 0, 0}, '0, 0, 0},
		// a zero window lives for one tick
		'{ROW_CFG, '0, '0, CFG_WINDOW, 16'd0},
		'{ROW_ITEM, '{REQ_TAG, 6'd3, 64'h0c0b0a, 0, 0, 0}, '0, 0, 0},
		'{ROW_ITEM, '{REQ_TICK, 6'd0, 0, 0, 0, 0}, '0, 0, 0},
		'{ROW_ITEM, '{REQ_TICK, 6'd0, 0, 0, 0, 0}, '0, 0, 0},
		'{ROW_CFG, '0, '0, CFG_WINDOW, 16'hffff},
		'{ROW_ITEM_EXP, '{REQ_CLEAR, 6'd0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, 0, 0}
	};

	initial begin
		error_count = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		key_len = '0;
		key_word0 = '0;
		key_word1 = '0;
		key_word2 = '0;
		key_word3 = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sh_filter_on = 1'b0;
		sh_window = 16'd10;
		sh_oldest = '0;
		sh_held = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				cfg_write(directed[i].idx, directed[i].data);
			end else begin
				send_item(directed[i].it, directed[i].kind == ROW_ITEM_EXP, directed[i].res);
				sender_gap();
			end
		end

		// filtering off with entries held
		random_phase(40, 40, 30, 15, 0);
		cfg_write(CFG_FILTER_ON, 16'd0);
		random_phase(80, 40, 30, 15, 3);
		cfg_write(CFG_FILTER_ON, 16'd1);
		cfg_write(CFG_WINDOW, 16'd0);
		random_phase(200, 50, 20, 20, 3);
		// long window, mostly new tags to push past a full table
		cfg_write(CFG_WINDOW, 16'hffff);
		random_phase(380, 15, 82, 1, 0);
		cfg_write(CFG_WINDOW, 16'($urandom_range(3, 8)));
		random_phase(350, 50, 20, 22, 2);
		cfg_write(CFG_WINDOW, 16'($urandom_range(1, 40)));
		random_phase(300, 45, 25, 22, 2);
		cfg_write(CFG_FILTER_ON, 16'd0);
		cfg_write(CFG_WINDOW, 16'($urandom));
		random_phase(60, 40, 30, 20, 3);

		wait_idle();
		repeat (600) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+sv
sv/tdwf_pkg.sv
sv/tdwf_store.sv
sv/tdwf_ctrl.sv
sv/tag_duplicate_window_filter_core.sv
sv/tdwf_checker.sv
tb/tag_duplicate_window_filter_core_tb.sv
